// File: rtl/core/hw_monitor_reading_converter_core_defines.svh
// Assertion macros for the hardware-monitor reading converter.
`ifndef HW_MONITOR_READING_CONVERTER_CORE_DEFINES_SVH
`define HW_MONITOR_READING_CONVERTER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define HWMRC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("hwmrc assertion failed");
`define HWMRC_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("hwmrc forbidden condition seen");
`else
`define HWMRC_ASSERT(label, prop)
`define HWMRC_NEVER(label, expr)
`endif
`endif

// File: rtl/core/hwmrc_pkg.sv
// Types and constant tables of the hardware-monitor reading converter.
`default_nettype none
package hwmrc_pkg;

	typedef enum logic [1:0] {
		KindTemp = 2'd0,
		KindFan  = 2'd1,
		KindVolt = 2'd2,
		KindNone = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] raw_byte;
		logic [1:0] temp_low_bits;
		logic [1:0] divisor_code;
		logic [2:0] volt_channel;
	} in_t;

	typedef struct packed {
		logic [28:0] converted_value;
		kind_t       kind_out;
	} out_t;

	localparam int unsigned FanNum    = 1350000;
	localparam int unsigned VoltDiv   = 2628;
	localparam int unsigned VoltOff   = 133;
	localparam int unsigned VoltGain  = 25;
	localparam int unsigned TempScale = 2500;
	localparam int unsigned VoltShift = 37;

	// Reciprocal of the voltage divisor, rounded up, exact for 24-bit dividends.
	localparam logic [25:0] VoltRecip =
		26'(((64'd1 << VoltShift) + 64'(VoltDiv) - 64'd1) / 64'(VoltDiv));

	// Channel multipliers split as mult = VoltDiv * quot + rem.
	localparam logic [11:0] VoltQuot0 = 12'(1250000 / VoltDiv);
	localparam logic [10:0] VoltRem0  = 11'(1250000 % VoltDiv);
	localparam logic [11:0] VoltQuot2 = 12'(1670000 / VoltDiv);
	localparam logic [10:0] VoltRem2  = 11'(1670000 % VoltDiv);
	localparam logic [11:0] VoltQuot3 = 12'(2600000 / VoltDiv);
	localparam logic [10:0] VoltRem3  = 11'(2600000 % VoltDiv);
	localparam logic [11:0] VoltQuot4 = 12'(6300000 / VoltDiv);
	localparam logic [10:0] VoltRem4  = 11'(6300000 % VoltDiv);

	// Temperature table in units of 10 mK.
	localparam logic [15:0] TempTable [256] = '{
		16'd20225, 16'd20435, 16'd20645, 16'd20855, 16'd21045, 16'd21245, 16'd21425,
		16'd21615, 16'd21785, 16'd21955, 16'd22125, 16'd22285, 16'd22445, 16'd22605,
		16'd22755, 16'd22895, 16'd23035, 16'd23175, 16'd23315, 16'd23445, 16'd23565,
		16'd23695, 16'd23815, 16'd23925, 16'd24045, 16'd24155, 16'd24265, 16'd24365,
		16'd24465, 16'd24565, 16'd24665, 16'd24765, 16'd24855, 16'd24945, 16'd25025,
		16'd25115, 16'd25195, 16'd25275, 16'd25355, 16'd25435, 16'd25515, 16'd25585,
		16'd25655, 16'd25725, 16'd25795, 16'd25865, 16'd25925, 16'd25995, 16'd26055,
		16'd26115, 16'd26175, 16'd26235, 16'd26295, 16'd26355, 16'd26405, 16'd26465,
		16'd26515, 16'd26575, 16'd26625, 16'd26675, 16'd26725, 16'd26775, 16'd26825,
		16'd26875, 16'd26925, 16'd26975, 16'd27025, 16'd27065, 16'd27115, 16'd27165,
		16'd27205, 16'd27255, 16'd27295, 16'd27345, 16'd27385, 16'd27435, 16'd27475,
		16'd27515, 16'd27565, 16'd27605, 16'd27645, 16'd27685, 16'd27735, 16'd27775,
		16'd27815, 16'd27855, 16'd27905, 16'd27945, 16'd27985, 16'd28025, 16'd28065,
		16'd28105, 16'd28155, 16'd28195, 16'd28235, 16'd28275, 16'd28315, 16'd28355,
		16'd28405, 16'd28445, 16'd28485, 16'd28525, 16'd28565, 16'd28615, 16'd28655,
		16'd28695, 16'd28735, 16'd28775, 16'd28825, 16'd28865, 16'd28905, 16'd28945,
		16'd28995, 16'd29035, 16'd29075, 16'd29125, 16'd29165, 16'd29205, 16'd29245,
		16'd29295, 16'd29335, 16'd29375, 16'd29425, 16'd29465, 16'd29505, 16'd29555,
		16'd29595, 16'd29635, 16'd29685, 16'd29725, 16'd29765, 16'd29815, 16'd29855,
		16'd29905, 16'd29945, 16'd29985, 16'd30035, 16'd30075, 16'd30125, 16'd30165,
		16'd30215, 16'd30255, 16'd30305, 16'd30345, 16'd30385, 16'd30435, 16'd30475,
		16'd30525, 16'd30565, 16'd30615, 16'd30655, 16'd30705, 16'd30755, 16'd30795,
		16'd30845, 16'd30885, 16'd30935, 16'd30975, 16'd31025, 16'd31075, 16'd31115,
		16'd31165, 16'd31215, 16'd31265, 16'd31305, 16'd31355, 16'd31405, 16'd31455,
		16'd31505, 16'd31545, 16'd31595, 16'd31645, 16'd31695, 16'd31745, 16'd31805,
		16'd31855, 16'd31905, 16'd31955, 16'd32005, 16'd32065, 16'd32115, 16'd32175,
		16'd32225, 16'd32285, 16'd32335, 16'd32395, 16'd32455, 16'd32515, 16'd32575,
		16'd32635, 16'd32695, 16'd32755, 16'd32825, 16'd32885, 16'd32955, 16'd33025,
		16'd33095, 16'd33155, 16'd33235, 16'd33305, 16'd33375, 16'd33455, 16'd33525,
		16'd33605, 16'd33685, 16'd33765, 16'd33855, 16'd33935, 16'd34025, 16'd34115,
		16'd34205, 16'd34295, 16'd34395, 16'd34495, 16'd34595, 16'd34695, 16'd34805,
		16'd34905, 16'd35015, 16'd35135, 16'd35245, 16'd35365, 16'd35495, 16'd35615,
		16'd35745, 16'd35875, 16'd36015, 16'd36145, 16'd36295, 16'd36435, 16'd36585,
		16'd36745, 16'd36895, 16'd37065, 16'd37225, 16'd37395, 16'd37575, 16'd37755,
		16'd37935, 16'd38125, 16'd38325, 16'd38525, 16'd38725, 16'd38935, 16'd39155,
		16'd39375, 16'd39605, 16'd39835, 16'd40075, 16'd40325, 16'd40575, 16'd40835,
		16'd41095, 16'd41375, 16'd41655, 16'd41935
	};

endpackage
`default_nettype wire

// File: rtl/core/hw_monitor_reading_converter_core.sv
// Four-stage pipeline converting raw hardware-monitor readings to physical units.
//
// channel | signals             | handshake
// input   | start, busy, cmd    | taken when start && !busy
// result  | done, res           | one-cycle strobe, no back-pressure
//
// Every item passes through the s1, s2 and s3 registers and the result register to its done strobe.
// One item may be accepted in every cycle; busy stays low.
// The depth is set by the voltage path: split multiply, reciprocal multiply, add.
// Reset clears the valid bits only; payload registers carry no reset.
`default_nettype none
`include "hw_monitor_reading_converter_core_defines.svh"
module hw_monitor_reading_converter_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire hwmrc_pkg::in_t  cmd,
	output logic                 done,
	output hwmrc_pkg::out_t      res
);

	// Fan quotient table, built at elaboration.
	logic [20:0] fan_rom [256];
	for (genvar b = 0; b < 256; b++) begin : g_fan
		if (b == 0) begin : g_zero
			assign fan_rom[b] = '0;
		end else begin : g_div
			localparam int unsigned Quot = hwmrc_pkg::FanNum / b;
			assign fan_rom[b] = 21'(Quot);
		end
	end

	logic accept;
	assign accept = start && !busy;
	assign busy   = 1'b0;

	// Stage 1: table reads, voltage operand, multiplier split.
	logic                valid_s1;
	hwmrc_pkg::kind_t    kind_s1;
	logic [15:0]         t0_s1, t1_s1;
	logic [1:0]          wt_s1;
	logic                interp_s1;
	logic [20:0]         fan_s1;
	logic [1:0]          code_s1;
	logic [12:0]         va_s1;
	logic [11:0]         vq_s1;
	logic [10:0]         vr_s1;

	logic [11:0] vq_d;
	logic [10:0] vr_d;
	logic [7:0]  next_idx;

	always_comb begin
		case (cmd.volt_channel)
			3'd0, 3'd1: begin vq_d = hwmrc_pkg::VoltQuot0; vr_d = hwmrc_pkg::VoltRem0; end
			3'd2: begin vq_d = hwmrc_pkg::VoltQuot2; vr_d = hwmrc_pkg::VoltRem2; end
			3'd3: begin vq_d = hwmrc_pkg::VoltQuot3; vr_d = hwmrc_pkg::VoltRem3; end
			3'd4: begin vq_d = hwmrc_pkg::VoltQuot4; vr_d = hwmrc_pkg::VoltRem4; end
			default: begin vq_d = '0; vr_d = '0; end
		endcase
		next_idx = cmd.raw_byte + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= cmd.kind;
			t0_s1     <= hwmrc_pkg::TempTable[cmd.raw_byte];
			t1_s1     <= hwmrc_pkg::TempTable[next_idx];
			wt_s1     <= cmd.temp_low_bits;
			interp_s1 <= (cmd.temp_low_bits != 2'd0) && (cmd.raw_byte != 8'hFF);
			fan_s1    <= fan_rom[cmd.raw_byte];
			code_s1   <= cmd.divisor_code;
			va_s1     <= 13'(13'(hwmrc_pkg::VoltGain) * 13'(cmd.raw_byte)
				+ 13'(hwmrc_pkg::VoltOff));
			vq_s1     <= vq_d;
			vr_s1     <= vr_d;
		end
	end

	// Stage 2: interpolation weights, fan divisor, split voltage products.
	logic             valid_s2;
	hwmrc_pkg::kind_t kind_s2;
	logic [17:0]      tsum_s2;
	logic [20:0]      fan_s2;
	logic [24:0]      vhi_s2;
	logic [23:0]      vlo_s2;

	logic [17:0] tsum_d;
	logic [2:0]  wlo;

	always_comb begin
		wlo = 3'd4 - 3'(wt_s1);
		if (interp_s1) begin
			tsum_d = 18'(t0_s1) * 18'(wlo) + 18'(t1_s1) * 18'(wt_s1);
		end else begin
			tsum_d = {t0_s1, 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2 <= kind_s1;
			tsum_s2 <= tsum_d;
			fan_s2  <= fan_s1 >> code_s1;
			vhi_s2  <= 25'(va_s1) * 25'(vq_s1);
			vlo_s2  <= 24'(va_s1) * 24'(vr_s1);
		end
	end

	// Stage 3: temperature scale, reciprocal multiply for the remainder part.
	logic             valid_s3;
	hwmrc_pkg::kind_t kind_s3;
	logic [28:0]      temp_s3;
	logic [20:0]      fan_s3;
	logic [24:0]      vhi_s3;
	logic [49:0]      vrec_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			kind_s3 <= kind_s2;
			temp_s3 <= 29'(tsum_s2) * 29'(hwmrc_pkg::TempScale);
			fan_s3  <= fan_s2;
			vhi_s3  <= vhi_s2;
			vrec_s3 <= 50'(vlo_s2) * 50'(hwmrc_pkg::VoltRecip);
		end
	end

	// Stage 4: finish the voltage quotient, select by kind.
	logic [28:0] value_d;
	logic [24:0] volt_d;

	always_comb begin
		volt_d = vhi_s3 + 25'(vrec_s3 >> hwmrc_pkg::VoltShift);
		case (kind_s3)
			hwmrc_pkg::KindTemp: value_d = temp_s3;
			hwmrc_pkg::KindFan:  value_d = 29'(fan_s3);
			hwmrc_pkg::KindVolt: value_d = 29'(volt_d);
			default:             value_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			res.converted_value <= value_d;
			res.kind_out        <= kind_s3;
		end
	end

	`HWMRC_ASSERT(a_latency, accept |-> ##4 done)
	`HWMRC_ASSERT(a_done_follows_s3, valid_s3 |=> done)
	`HWMRC_NEVER(a_none_zero, done && res.kind_out == hwmrc_pkg::KindNone
		&& res.converted_value != 29'd0)
	`HWMRC_NEVER(a_fan_range, done && res.kind_out == hwmrc_pkg::KindFan
		&& res.converted_value > 29'(hwmrc_pkg::FanNum))

endmodule
`default_nettype wire

// File: test/hw_monitor_reading_converter_checker.sv
// Checker for the reading converter: predicts each converted reading and compares results.
`default_nettype none
module hw_monitor_reading_converter_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            busy,
	input  wire hwmrc_pkg::in_t  cmd,
	input  wire logic            done,
	input  wire hwmrc_pkg::out_t res,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	hwmrc_pkg::out_t expected_readings[$];

	function automatic logic [28:0] convert_reading(hwmrc_pkg::in_t r);
		longint unsigned val;
		longint unsigned mult;
		val = 0;
		case (r.kind)
			hwmrc_pkg::KindTemp: begin
				if (r.temp_low_bits == 2'd0 || r.raw_byte == 8'd255)
					val = longint'(hwmrc_pkg::TempTable[r.raw_byte]) * 10000;
				else
					val = (longint'(hwmrc_pkg::TempTable[r.raw_byte]) *
						(4 - r.temp_low_bits) +
						longint'(hwmrc_pkg::TempTable[r.raw_byte + 9'd1]) *
						r.temp_low_bits) * 2500;
			end
			hwmrc_pkg::KindFan: begin
				if (r.raw_byte != 8'd0)
					val = (longint'(1350000) / r.raw_byte) >> r.divisor_code;
			end
			hwmrc_pkg::KindVolt: begin
				case (r.volt_channel)
					3'd0, 3'd1: mult = 1250000;
					3'd2: mult = 1670000;
					3'd3: mult = 2600000;
					3'd4: mult = 6300000;
					default: mult = 0;
				endcase
				val = ((25 * longint'(r.raw_byte) + 133) * mult) / 2628;
			end
			default: val = 0;
		endcase
		return val[28:0];
	endfunction

	assign pending = expected_readings.size();

	always @(posedge clk or negedge arst_n) begin
		hwmrc_pkg::out_t want;
		if (!arst_n) begin
			errors = 0;
			expected_readings.delete();
		end else begin
			if (start && !busy)
				expected_readings.push_back('{convert_reading(cmd), cmd.kind});
			if (done) begin
				if (expected_readings.size() == 0) begin
					errors++;
					$display("%0t: unexpected result value=%0d kind=%0d", $time,
						res.converted_value, res.kind_out);
				end else begin
					want = expected_readings.pop_front();
					if (res.converted_value !== want.converted_value) begin
						errors++;
						$display("%0t: value expected %0d actual %0d", $time,
							want.converted_value, res.converted_value);
					end
					if (res.kind_out !== want.kind_out) begin
						errors++;
						$display("%0t: kind expected %0d actual %0d", $time,
							want.kind_out, res.kind_out);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: test/tb_hw_monitor_reading_converter_core.sv
// Testbench top for the reading converter: stimulus, clock, reset and verdict.
`default_nettype none
module tb_hw_monitor_reading_converter_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	logic            done;
	hwmrc_pkg::in_t  cmd = '0;
	hwmrc_pkg::out_t res;
	int              errors;
	int              pending;
	int              readings_sent = 0;

	always #1 clk = ~clk;

	hw_monitor_reading_converter_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .res(res)
	);

	hw_monitor_reading_converter_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .res(res), .errors(errors), .pending(pending)
	);

	// Present one item and hold it until taken.
	task automatic send_reading(hwmrc_pkg::in_t r);
		cmd <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		readings_sent++;
	endtask

	task automatic idle_gap();
		int n;
		if ($urandom_range(0, 99) < 60)
			return;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic hwmrc_pkg::in_t random_reading();
		hwmrc_pkg::in_t r;
		r.raw_byte      = 8'($urandom);
		r.temp_low_bits = 2'($urandom);
		r.divisor_code  = 2'($urandom);
		r.volt_channel  = 3'($urandom);
		r.kind = hwmrc_pkg::kind_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
		if ($urandom_range(0, 7) == 0)
			r.raw_byte = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
		return r;
	endfunction

	initial begin
		int i;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Directed: table ends, interpolation, fan zero and divisors, all channels.
		send_reading('{hwmrc_pkg::KindTemp, 8'd0, 2'd0, 2'd0, 3'd0});
		send_reading('{hwmrc_pkg::KindTemp, 8'd0, 2'd3, 2'd3, 3'd7});
		send_reading('{hwmrc_pkg::KindTemp, 8'd254, 2'd3, 2'd0, 3'd0});
		send_reading('{hwmrc_pkg::KindTemp, 8'd255, 2'd2, 2'd0, 3'd0});
		send_reading('{hwmrc_pkg::KindTemp, 8'd255, 2'd0, 2'd0, 3'd0});
		send_reading('{hwmrc_pkg::KindFan, 8'd0, 2'd0, 2'd0, 3'd0});
		send_reading('{hwmrc_pkg::KindFan, 8'd1, 2'd0, 2'd0, 3'd0});
		send_reading('{hwmrc_pkg::KindFan, 8'd1, 2'd0, 2'd3, 3'd0});
		send_reading('{hwmrc_pkg::KindFan, 8'd255, 2'd3, 2'd2, 3'd7});
		for (i = 0; i < 8; i++) begin
			send_reading('{hwmrc_pkg::KindVolt, 8'd255, 2'd0, 2'd0, 3'(i)});
			idle_gap();
		end
		send_reading('{hwmrc_pkg::KindVolt, 8'd0, 2'd0, 2'd0, 3'd4});
		send_reading('{hwmrc_pkg::KindNone, 8'd255, 2'd3, 2'd3, 3'd7});
		send_reading('{hwmrc_pkg::KindNone, 8'd0, 2'd0, 2'd0, 3'd0});
		for (i = 0; i < 1100; i++) begin
			send_reading(random_reading());
			if (i % 200 > 40)
				idle_gap();
		end
		start <= 1'b0;
		i = 0;
		while (pending != 0 && i < 1000) begin
			@(negedge clk);
			i++;
		end
		repeat (8) @(negedge clk);
		$display("Sent %0d readings: temperature, fan, voltage and unknown kinds,", readings_sent);
		$display("including table ends, zero bytes, all divisors and all channels.");
		if (errors == 0 && pending == 0)
			$display("tb_hw_monitor_reading_converter_core: clean");
		else
			$display("tb_hw_monitor_reading_converter_core: errors");
		$finish;
	end

	initial begin
		#200000;
		$display("tb_hw_monitor_reading_converter_core: errors");
		$finish;
	end
endmodule
`default_nettype wire
